### design/port_forward_nat_rewrite_macros.svh
// Assertion macros for the port forwarding NAT rewrite block.
// Expects signals named clk and arst_n in the scope of every use.
`ifndef PORT_FORWARD_NAT_REWRITE_MACROS_SVH
`define PORT_FORWARD_NAT_REWRITE_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define PFNR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked while out of reset.
`define PFNR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/pfnr_pkg.sv
// Shared types and constants of the port forwarding NAT rewrite block.
// Has no dependencies; used by pfnr_ram and port_forward_nat_rewrite.
`default_nettype none

package pfnr_pkg;

	localparam int CLIENT_TABLE_DEPTH_DEF = 65536;
	// One client entry holds the client IP above the client MAC.
	localparam int CLIENT_ENTRY_W = 80;

	localparam int IN_TDATA_W  = 272;
	localparam int OUT_TDATA_W = 224;
	localparam int ACTION_W    = 2;
	localparam int APB_AW      = 4;
	localparam int APB_DW      = 32;

	localparam logic [7:0] PROTO_TCP     = 8'd6;
	localparam int         TCP_HDR_BYTES = 20;

	// Reset values of the configuration registers, wire byte order.
	localparam logic [31:0] LOCAL_IP_RST    = 32'd3232261040;
	localparam logic [15:0] LOCAL_PORT_RST  = 16'd8000;
	localparam logic [31:0] TARGET_IP_RST   = 32'd759981109;
	localparam logic [15:0] TARGET_PORT_RST = 16'd80;

	// Register word index, taken from paddr[3:2].
	localparam logic [1:0] REG_LOCAL_IP    = 2'd0;
	localparam logic [1:0] REG_LOCAL_PORT  = 2'd1;
	localparam logic [1:0] REG_TARGET_IP   = 2'd2;
	localparam logic [1:0] REG_TARGET_PORT = 2'd3;

	localparam logic [ACTION_W-1:0] ACT_PASS    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FORWARD = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_RETURN  = 2'd2;

	// Input word; the last member sits in the lowest bits.
	typedef struct packed {
		logic [3:0]  tdata_pad;
		logic [47:0] dest_mac;
		logic [47:0] source_mac;
		logic [15:0] tcp_checksum;
		logic [15:0] ip_checksum;
		logic [15:0] buffer_length;
		logic [15:0] ip_total_length;
		logic [3:0]  header_words;
		logic [7:0]  protocol_number;
		logic [15:0] dest_port;
		logic [15:0] source_port;
		logic [31:0] dest_ip;
		logic [31:0] source_ip;
	} in_item_t;

	// Result word without the action code, which travels in tuser.
	typedef struct packed {
		logic [47:0] out_dest_mac;
		logic [47:0] out_source_mac;
		logic [15:0] out_tcp_checksum;
		logic [15:0] out_ip_checksum;
		logic [15:0] out_dest_port;
		logic [15:0] out_source_port;
		logic [31:0] out_dest_ip;
		logic [31:0] out_source_ip;
	} out_item_t;

endpackage

`default_nettype wire

### design/pfnr_ram.sv
// Generic single-port synchronous RAM with a registered read port.
// Default sizes come from pfnr_pkg.
`default_nettype none

module pfnr_ram #(
	parameter int WIDTH = pfnr_pkg::CLIENT_ENTRY_W,
	parameter int DEPTH = pfnr_pkg::CLIENT_TABLE_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

### design/port_forward_nat_rewrite.sv
// Port forwarding NAT rewrite of IPv4/TCP headers, top level.
// Depends on pfnr_pkg, pfnr_ram and port_forward_nat_rewrite_macros.svh.
//
// Usage:
// One packet header arrives per word on the s_axis channel and one rewritten
// header leaves per word on the m_axis channel, with the action code in
// m_axis_tuser. Client packets to local_ip:local_port are sent on to
// target_ip:target_port and the client is remembered by its source port;
// target replies to local_ip go back to the remembered client. Anything else
// passes unchanged. The four addresses and ports sit behind the APB port.
//
// Timing: a header is accepted, decoded, turned into a table index with the
// client table read or written in that same cycle, summed and folded. The
// output register is loaded from the fold state. The next word is accepted
// in the idle state that follows the load of the result, so the block takes
// no new word before it is through with the last one. The sequence through
// the single table port and the one's-complement sum and fold stages sets the pace.
//
// Reset: the client table is cleared one entry per cycle right after reset,
// through all CLIENT_TABLE_DEPTH entries, with s_axis_tready low; APB writes work all the
// while. If the receiver stalls, the result waits in the output register
// and one more word is accepted and worked up to the point where it needs
// that register.
`default_nettype none
`include "port_forward_nat_rewrite_macros.svh"

module port_forward_nat_rewrite #(
	parameter int CLIENT_TABLE_DEPTH = pfnr_pkg::CLIENT_TABLE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// Header in.
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// From bit 0 up: source_ip, dest_ip, source_port, dest_port,
	// protocol_number, header_words, ip_total_length, buffer_length,
	// ip_checksum, tcp_checksum, source_mac, dest_mac, zero pad.
	input  logic [pfnr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// Header out.
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// From bit 0 up: out_source_ip, out_dest_ip, out_source_port,
	// out_dest_port, out_ip_checksum, out_tcp_checksum, out_source_mac,
	// out_dest_mac.
	output logic [pfnr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	// action.
	output logic [pfnr_pkg::ACTION_W-1:0]       m_axis_tuser,
	// Configuration.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [pfnr_pkg::APB_AW-1:0]         paddr,
	input  logic [pfnr_pkg::APB_DW-1:0]         pwdata,
	output logic [pfnr_pkg::APB_DW-1:0]         prdata,
	output logic                                pready
);

	import pfnr_pkg::*;

	localparam int              IDX_W    = $clog2(CLIENT_TABLE_DEPTH);
	localparam logic [16:0]     DEPTH_V  = 17'(CLIENT_TABLE_DEPTH);
	// floor(2^32 / depth): the quotient estimate is exact or one too small.
	localparam logic [31:0]     RECIP    = 32'((64'd1 << 32) / CLIENT_TABLE_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENT_TABLE_DEPTH - 1);

	// Sequencer states, one-hot.
	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_DEC   = 6'b000100,
		S_IDX   = 6'b001000,
		S_SUM   = 6'b010000,
		S_FOLD  = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers.
	logic [31:0] local_ip_q, target_ip_q;
	logic [15:0] local_port_q, target_port_q;
	logic        cfg_wr;

	// Learned target MAC.
	logic [47:0] target_mac_q;
	logic        tmac_known_q;

	// Work registers of the item in flight.
	in_item_t    in_w;
	in_item_t    item_q;
	logic        fwd_q, ret_q;
	logic [15:0] port_q;
	logic [47:0] prod_q;
	logic [47:0] fwd_mac_q;
	logic [IDX_W-1:0] clr_q;

	// Sum stage results.
	logic [19:0]     ip_sum_q, tcp_sum_q;
	out_item_t       res_q;
	logic [ACTION_W-1:0] act_q;
	logic            hit_q;

	// Output register.
	out_item_t       out_q;
	logic [ACTION_W-1:0] act_out_q;
	logic            out_valid_q;

	// Combinational nets.
	logic        accept;
	logic        out_load;
	logic [16:0] hdr_min;
	logic        pkt_ok, dest_local, is_fwd, is_ret, learn;
	logic [15:0] idx_port;
	logic [47:0] prod_w;
	logic [15:0] quot_w;
	logic [32:0] qd_w;
	logic [17:0] rem_w, red_w;
	logic [IDX_W-1:0] idx_w;
	logic             ram_we;
	logic [IDX_W-1:0] ram_addr;
	logic [CLIENT_ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [31:0] cip, new_dip;
	logic [47:0] cmac;
	logic [15:0] old_port, new_port;
	logic [19:0] common_w;
	logic [15:0] ip_ck, tcp_ck;
	out_item_t   out_w;

	// Folds a 20-bit one's-complement sum to 16 bits and complements it.
	function automatic logic [15:0] csum_fold(input logic [19:0] s);
		logic [16:0] f1;
		logic [15:0] f2;
		f1 = {1'b0, s[15:0]} + {13'b0, s[19:16]};
		f2 = f1[15:0] + {15'b0, f1[16]};
		return ~f2;
	endfunction

	// ------------------------------------------------------------------
	// Configuration port. Registers are word aligned; the low address
	// bits are not decoded.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q    <= LOCAL_IP_RST;
			local_port_q  <= LOCAL_PORT_RST;
			target_ip_q   <= TARGET_IP_RST;
			target_port_q <= TARGET_PORT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LOCAL_IP:    local_ip_q    <= pwdata;
				REG_LOCAL_PORT:  local_port_q  <= pwdata[15:0];
				REG_TARGET_IP:   target_ip_q   <= pwdata;
				REG_TARGET_PORT: target_port_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LOCAL_IP:    prdata = local_ip_q;
			REG_LOCAL_PORT:  prdata = {16'b0, local_port_q};
			REG_TARGET_IP:   prdata = target_ip_q;
			REG_TARGET_PORT: prdata = {16'b0, target_port_q};
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input handshake. A word is taken only in the idle state, which is
	// entered again as soon as the result is loaded into the output register.
	// ------------------------------------------------------------------
	assign in_w          = s_axis_tdata;
	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_w;
		end
	end

	// ------------------------------------------------------------------
	// Decode: packet checks and rule match. Learning of the target MAC
	// comes first, so a packet that both teaches the MAC and is forwarded
	// already uses the MAC it carries.
	// ------------------------------------------------------------------
	assign hdr_min    = {11'b0, item_q.header_words, 2'b00} + 17'(TCP_HDR_BYTES);
	assign pkt_ok     = (item_q.protocol_number == PROTO_TCP) &&
	                    ({1'b0, item_q.buffer_length} >= hdr_min) &&
	                    (item_q.buffer_length >= item_q.ip_total_length);
	assign dest_local = (item_q.dest_ip == local_ip_q);
	assign is_fwd     = pkt_ok && dest_local && (item_q.dest_port == local_port_q);
	assign is_ret     = pkt_ok && !is_fwd && dest_local &&
	                    (item_q.source_ip == target_ip_q) &&
	                    (item_q.source_port == target_port_q);
	assign learn      = !tmac_known_q && (item_q.source_ip == target_ip_q);

	// Forwarding stores under the client's source port, a return looks up
	// the destination port.
	assign idx_port = is_fwd ? item_q.source_port : item_q.dest_port;
	assign prod_w   = {32'b0, idx_port} * {16'b0, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_mac_q <= '0;
			tmac_known_q <= 1'b0;
			fwd_q        <= 1'b0;
			ret_q        <= 1'b0;
		end else if (state_q == S_DEC) begin
			fwd_q <= is_fwd;
			ret_q <= is_ret;
			if (learn) begin
				target_mac_q <= item_q.source_mac;
				tmac_known_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DEC) begin
			port_q    <= idx_port;
			prod_q    <= prod_w;
			fwd_mac_q <= learn ? item_q.source_mac : target_mac_q;
		end
	end

	// ------------------------------------------------------------------
	// Index: port modulo the table depth, by reciprocal and one
	// correction step. For a power-of-two depth this reduces to a mask.
	// ------------------------------------------------------------------
	assign quot_w = prod_q[47:32];
	assign qd_w   = {17'b0, quot_w} * {16'b0, DEPTH_V};
	assign rem_w  = {2'b0, port_q} - qd_w[17:0];
	assign red_w  = (rem_w >= {1'b0, DEPTH_V}) ? (rem_w - {1'b0, DEPTH_V}) : rem_w;
	assign idx_w  = red_w[IDX_W-1:0];

	// ------------------------------------------------------------------
	// Client table: one entry per client port, client IP above client
	// MAC. Written by the clearing pass and by forwarded packets, read for
	// everything else. Only one item is in flight, so a read never meets
	// an earlier write to the same entry.
	// ------------------------------------------------------------------
	assign ram_we    = (state_q == S_CLEAR) || ((state_q == S_IDX) && fwd_q);
	assign ram_addr  = (state_q == S_CLEAR) ? clr_q : idx_w;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : {item_q.source_ip, item_q.source_mac};

	pfnr_ram #(
		.WIDTH (CLIENT_ENTRY_W),
		.DEPTH (CLIENT_TABLE_DEPTH)
	) u_client_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// ------------------------------------------------------------------
	// Sum: incremental checksum update. The one's-complement adds of the
	// word-by-word update are associative, so all replaced and new words
	// go into one wide sum that is folded in the next cycle; the result
	// is zero only when every term is zero, just as with the chained form.
	// ------------------------------------------------------------------
	assign cip      = ram_rdata[79:48];
	assign cmac     = ram_rdata[47:0];
	assign new_dip  = fwd_q ? target_ip_q : cip;
	assign old_port = fwd_q ? item_q.dest_port : item_q.source_port;
	assign new_port = fwd_q ? target_port_q : local_port_q;

	assign common_w = {4'b0, ~item_q.dest_ip[31:16]} + {4'b0, ~item_q.dest_ip[15:0]} +
	                  {4'b0, new_dip[31:16]} + {4'b0, new_dip[15:0]} +
	                  {4'b0, ~item_q.source_ip[31:16]} + {4'b0, ~item_q.source_ip[15:0]} +
	                  {4'b0, local_ip_q[31:16]} + {4'b0, local_ip_q[15:0]};

	always_ff @(posedge clk) begin
		if (state_q == S_SUM) begin
			ip_sum_q  <= common_w + {4'b0, ~item_q.ip_checksum};
			tcp_sum_q <= common_w + {4'b0, ~item_q.tcp_checksum} +
			             {4'b0, ~old_port} + {4'b0, new_port};
			hit_q     <= fwd_q | ret_q;
			act_q     <= fwd_q ? ACT_FORWARD : (ret_q ? ACT_RETURN : ACT_PASS);

			res_q.out_source_ip    <= (fwd_q | ret_q) ? local_ip_q : item_q.source_ip;
			res_q.out_dest_ip      <= fwd_q ? target_ip_q :
			                          (ret_q ? cip : item_q.dest_ip);
			res_q.out_source_port  <= ret_q ? local_port_q : item_q.source_port;
			res_q.out_dest_port    <= fwd_q ? target_port_q : item_q.dest_port;
			res_q.out_ip_checksum  <= item_q.ip_checksum;
			res_q.out_tcp_checksum <= item_q.tcp_checksum;
			res_q.out_source_mac   <= (fwd_q | ret_q) ? item_q.dest_mac : item_q.source_mac;
			res_q.out_dest_mac     <= fwd_q ? fwd_mac_q :
			                          (ret_q ? cmac : item_q.dest_mac);
		end
	end

	// ------------------------------------------------------------------
	// Fold and output register. The fold state holds until the output
	// register is free or being emptied in the same cycle.
	// ------------------------------------------------------------------
	assign ip_ck    = csum_fold(ip_sum_q);
	assign tcp_ck   = csum_fold(tcp_sum_q);
	assign out_load = (state_q == S_FOLD) && (!out_valid_q || m_axis_tready);

	// Rewritten headers take the folded checksums, passed ones keep theirs.
	always_comb begin
		out_w = res_q;
		if (hit_q) begin
			out_w.out_ip_checksum  = ip_ck;
			out_w.out_tcp_checksum = tcp_ck;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q     <= out_w;
			act_out_q <= act_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign m_axis_tuser  = act_out_q;

	// ------------------------------------------------------------------
	// Sequencer, including the table clearing pass after reset.
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == LAST_IDX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					state_d = S_DEC;
				end
			end
			S_DEC:  state_d = S_IDX;
			S_IDX:  state_d = S_SUM;
			S_SUM:  state_d = S_FOLD;
			S_FOLD: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	`PFNR_ASSERT_NEXT(a_accept_starts_decode, accept, state_q == S_DEC, "accept without decode")
	`PFNR_ASSERT_NEXT(a_load_shows_result, out_load, m_axis_tvalid, "loaded result not shown")
	`PFNR_ASSERT_NEXT(a_target_mac_sticky, tmac_known_q, tmac_known_q && $stable(target_mac_q), "target MAC changed")
	`PFNR_ASSERT_NOW(a_rewrite_uses_local_ip, m_axis_tvalid && (m_axis_tuser != ACT_PASS), out_q.out_source_ip == local_ip_q, "bad source IP")

endmodule

`default_nettype wire

### tb/tb_port_forward_nat_rewrite.sv
// Self-checking testbench for port_forward_nat_rewrite: header words in, rewritten words out.
// Depends on pfnr_pkg for the word layouts, register indexes and action codes.
// Registers are written over APB, and every result is checked against a model kept here.
`timescale 1ns / 1ps

module tb_port_forward_nat_rewrite;

	import pfnr_pkg::*;

	// The block loads its output register after the decode, index, sum and fold states that follow the accepting edge.
	localparam int LATENCY        = 4;
	localparam int RAND_PER_PHASE = 382;
	localparam int RX_HOLD_CYCLES = 150;
	localparam int MAX_REPORTS    = 40;

	// One expected result: the action code and the rewritten header.
	typedef struct {
		logic [ACTION_W-1:0] action;
		out_item_t           hdr;
	} rewrite_t;

	// Follows the block's register and table state, works out the rewrite of
	// every accepted header, and checks the results in order.
	class forward_checker;
		logic [31:0] cfg_local_ip    = LOCAL_IP_RST;
		logic [15:0] cfg_local_port  = LOCAL_PORT_RST;
		logic [31:0] cfg_target_ip   = TARGET_IP_RST;
		logic [15:0] cfg_target_port = TARGET_PORT_RST;
		logic [47:0] target_mac      = '0;
		bit          mac_learned     = 1'b0;
		bit [31:0]   client_ip_of  [CLIENT_TABLE_DEPTH_DEF];
		bit [47:0]   client_mac_of [CLIENT_TABLE_DEPTH_DEF];
		rewrite_t    expected_rewrites[$];
		int          errors  = 0;
		int          reports = 0;
		int          n_forward = 0;
		int          n_return  = 0;
		int          n_pass    = 0;

		// One's-complement add with the carry folded back in.
		static function logic [15:0] oc_sum(logic [15:0] a, logic [15:0] b);
			logic [16:0] s;
			s = {1'b0, a} + {1'b0, b};
			return s[15:0] + {15'd0, s[16]};
		endfunction

		// Incremental update of an inverted checksum when word m becomes n.
		static function logic [15:0] swap_word(logic [15:0] acc, logic [15:0] m,
				logic [15:0] n);
			return oc_sum(oc_sum(acc, ~m), n);
		endfunction

		static function logic [15:0] swap_addr(logic [15:0] acc, logic [31:0] m,
				logic [31:0] n);
			acc = swap_word(acc, m[31:16], n[31:16]);
			return swap_word(acc, m[15:0], n[15:0]);
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] value);
			case (idx)
				REG_LOCAL_IP:    cfg_local_ip    = value;
				REG_LOCAL_PORT:  cfg_local_port  = value[15:0];
				REG_TARGET_IP:   cfg_target_ip   = value;
				REG_TARGET_PORT: cfg_target_port = value[15:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_rewrites.size();
		endfunction

		function void take_header(in_item_t h);
			rewrite_t    r;
			logic [15:0] ia;
			logic [15:0] ta;
			int          need;
			int          k;
			if (!mac_learned && h.source_ip == cfg_target_ip) begin
				target_mac  = h.source_mac;
				mac_learned = 1'b1;
			end
			r.action                 = ACT_PASS;
			r.hdr.out_source_ip      = h.source_ip;
			r.hdr.out_dest_ip        = h.dest_ip;
			r.hdr.out_source_port    = h.source_port;
			r.hdr.out_dest_port      = h.dest_port;
			r.hdr.out_ip_checksum    = h.ip_checksum;
			r.hdr.out_tcp_checksum   = h.tcp_checksum;
			r.hdr.out_source_mac     = h.source_mac;
			r.hdr.out_dest_mac       = h.dest_mac;
			need = int'(h.header_words) * 4 + TCP_HDR_BYTES;
			if (h.protocol_number == PROTO_TCP && int'(h.buffer_length) >= need &&
					h.buffer_length >= h.ip_total_length) begin
				ia = ~h.ip_checksum;
				ta = ~h.tcp_checksum;
				if (h.dest_ip == cfg_local_ip && h.dest_port == cfg_local_port) begin
					k = int'(h.source_port) % CLIENT_TABLE_DEPTH_DEF;
					client_ip_of[k]  = h.source_ip;
					client_mac_of[k] = h.source_mac;
					ia = swap_addr(ia, h.dest_ip, cfg_target_ip);
					ia = swap_addr(ia, h.source_ip, cfg_local_ip);
					ta = swap_addr(ta, h.dest_ip, cfg_target_ip);
					ta = swap_addr(ta, h.source_ip, cfg_local_ip);
					ta = swap_word(ta, h.dest_port, cfg_target_port);
					r.action               = ACT_FORWARD;
					r.hdr.out_dest_ip      = cfg_target_ip;
					r.hdr.out_source_ip    = cfg_local_ip;
					r.hdr.out_dest_port    = cfg_target_port;
					r.hdr.out_source_mac   = h.dest_mac;
					r.hdr.out_dest_mac     = target_mac;
					r.hdr.out_ip_checksum  = ~ia;
					r.hdr.out_tcp_checksum = ~ta;
				end else if (h.source_ip == cfg_target_ip && h.source_port == cfg_target_port
						&& h.dest_ip == cfg_local_ip) begin
					k = int'(h.dest_port) % CLIENT_TABLE_DEPTH_DEF;
					ia = swap_addr(ia, h.dest_ip, client_ip_of[k]);
					ia = swap_addr(ia, h.source_ip, cfg_local_ip);
					ta = swap_addr(ta, h.dest_ip, client_ip_of[k]);
					ta = swap_addr(ta, h.source_ip, cfg_local_ip);
					ta = swap_word(ta, h.source_port, cfg_local_port);
					r.action               = ACT_RETURN;
					r.hdr.out_dest_ip      = client_ip_of[k];
					r.hdr.out_source_ip    = cfg_local_ip;
					r.hdr.out_source_port  = cfg_local_port;
					r.hdr.out_source_mac   = h.dest_mac;
					r.hdr.out_dest_mac     = client_mac_of[k];
					r.hdr.out_ip_checksum  = ~ia;
					r.hdr.out_tcp_checksum = ~ta;
				end
			end
			expected_rewrites.push_back(r);
		endfunction

		function bit field_differs(string name, logic [47:0] want, logic [47:0] got);
			if (want === got)
				return 1'b0;
			if (reports < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			reports++;
			return 1'b1;
		endfunction

		function void check_rewrite(logic [ACTION_W-1:0] act, out_item_t got);
			rewrite_t want;
			bit       bad;
			if (expected_rewrites.size() == 0) begin
				errors++;
				$display("%0t: result word with no header pending, action %0d", $time, act);
				return;
			end
			want = expected_rewrites.pop_front();
			case (want.action)
				ACT_FORWARD: n_forward++;
				ACT_RETURN:  n_return++;
				default:     n_pass++;
			endcase
			bad = field_differs("action", want.action, act);
			bad |= field_differs("out_source_ip", want.hdr.out_source_ip, got.out_source_ip);
			bad |= field_differs("out_dest_ip", want.hdr.out_dest_ip, got.out_dest_ip);
			bad |= field_differs("out_source_port", want.hdr.out_source_port,
				got.out_source_port);
			bad |= field_differs("out_dest_port", want.hdr.out_dest_port, got.out_dest_port);
			bad |= field_differs("out_ip_checksum", want.hdr.out_ip_checksum,
				got.out_ip_checksum);
			bad |= field_differs("out_tcp_checksum", want.hdr.out_tcp_checksum,
				got.out_tcp_checksum);
			bad |= field_differs("out_source_mac", want.hdr.out_source_mac,
				got.out_source_mac);
			bad |= field_differs("out_dest_mac", want.hdr.out_dest_mac, got.out_dest_mac);
			if (bad)
				errors++;
		endfunction

		function void check_leftovers();
			if (expected_rewrites.size() != 0) begin
				errors++;
				$display("%0t: %0d expected results never arrived", $time,
					expected_rewrites.size());
			end
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// From bit 0 up: source_ip, dest_ip, source_port, dest_port, protocol_number,
	// header_words, ip_total_length, buffer_length, ip_checksum, tcp_checksum,
	// source_mac, dest_mac, zero pad.
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// From bit 0 up: out_source_ip, out_dest_ip, out_source_port, out_dest_port,
	// out_ip_checksum, out_tcp_checksum, out_source_mac, out_dest_mac.
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	// action.
	logic [ACTION_W-1:0]    m_axis_tuser;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [APB_AW-1:0]      paddr = '0;
	logic [APB_DW-1:0]      pwdata = '0;
	logic [APB_DW-1:0]      prdata;
	logic                   pready;

	forward_checker chk = new();

	// Shared between the stimulus and the receiver: a quiet stretch turns off
	// all idling, and a hold request makes the receiver stall for a long time.
	bit no_idle     = 1'b0;
	bit rx_hold_req = 1'b0;

	port_forward_nat_rewrite uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Hard stop. The slowest legal run, including the table clear after reset,
	// stays well under a quarter of this.
	initial begin
		#20000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Sender gap lengths: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Receiver. Stalls are decided at the falling edge so that tready is
	// stable at the rising edge where the monitor samples the handshake.
	// A hold request keeps tready low for a counted stretch; the block then
	// fills up and drops s_axis_tready while the sender keeps offering.
	initial begin : receiver
		int stall_left;
		int hold_count;
		stall_left = 0;
		hold_count = 0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				m_axis_tready <= 1'b0;
				hold_count++;
				if (hold_count == RX_HOLD_CYCLES) begin
					rx_hold_req = 1'b0;
					hold_count  = 0;
				end
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (!no_idle && $urandom_range(0, 99) < 20) begin
				stall_left = $urandom_range(0, 99) < 80 ? $urandom_range(1, 3)
					: $urandom_range(10, 40);
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Every result word accepted at a rising edge is checked right away.
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			chk.check_rewrite(m_axis_tuser, out_item_t'(m_axis_tdata));
	end

	// Offer one header word, optionally after a gap, and wait for the accept.
	// The word is handed to the checker at the edge where it is taken.
	task automatic send_header(input in_item_t h);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= h;
		do @(posedge clk); while (!s_axis_tready);
		chk.take_header(h);
	endtask

	// Stop offering, then wait until every expected result is in and the
	// pipeline has had time to settle.
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (chk.pending() != 0) @(posedge clk);
		repeat (LATENCY + 3) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle until pready.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		chk.set_reg(idx, value);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic program_ports(input logic [31:0] lip, input logic [15:0] lport,
			input logic [31:0] tip, input logic [15:0] tport);
		write_reg(REG_LOCAL_IP, lip);
		write_reg(REG_LOCAL_PORT, {16'd0, lport});
		write_reg(REG_TARGET_IP, tip);
		write_reg(REG_TARGET_PORT, {16'd0, tport});
	endtask

	// Fully random header; every bit of every field but the zero pad is free.
	function automatic in_item_t any_header();
		in_item_t h;
		h.tdata_pad       = '0;
		h.source_ip       = $urandom;
		h.dest_ip         = $urandom;
		h.source_port     = 16'($urandom);
		h.dest_port       = 16'($urandom);
		h.protocol_number = 8'($urandom);
		h.header_words    = 4'($urandom);
		h.ip_total_length = 16'($urandom);
		h.buffer_length   = 16'($urandom);
		h.ip_checksum     = 16'($urandom);
		h.tcp_checksum    = 16'($urandom);
		h.source_mac      = {16'($urandom), 32'($urandom)};
		h.dest_mac        = {16'($urandom), 32'($urandom)};
		return h;
	endfunction

	// Make a header TCP with lengths that pass both size checks. The buffer
	// length is half the time near the header size and otherwise anywhere above it.
	function automatic in_item_t as_valid_tcp(input in_item_t h);
		int need;
		int blen;
		h.protocol_number = PROTO_TCP;
		h.header_words    = 4'($urandom);
		need = int'(h.header_words) * 4 + TCP_HDR_BYTES;
		blen = $urandom_range(0, 1) ? $urandom_range(need, need + 1500)
			: $urandom_range(need, 65535);
		h.buffer_length   = 16'(blen);
		h.ip_total_length = $urandom_range(0, 9) == 0 ? 16'(blen)
			: 16'($urandom_range(0, blen));
		return h;
	endfunction

	// Client packet aimed at the listening address and port.
	function automatic in_item_t client_header(input logic [15:0] port);
		in_item_t h;
		h             = any_header();
		h.dest_ip     = chk.cfg_local_ip;
		h.dest_port   = chk.cfg_local_port;
		h.source_port = port;
		return as_valid_tcp(h);
	endfunction

	// Reply from the target back to the listening address, to a client port.
	function automatic in_item_t target_reply(input logic [15:0] port);
		in_item_t h;
		h             = any_header();
		h.source_ip   = chk.cfg_target_ip;
		h.source_port = chk.cfg_target_port;
		h.dest_ip     = chk.cfg_local_ip;
		h.dest_port   = port;
		return as_valid_tcp(h);
	endfunction

	// A well-formed forward or return with exactly one thing spoiled.
	function automatic in_item_t spoiled_header(input logic [15:0] port);
		in_item_t h;
		bit       fwd;
		int       need;
		fwd = $urandom_range(0, 1);
		h   = fwd ? client_header(port) : target_reply(port);
		need = int'(h.header_words) * 4 + TCP_HDR_BYTES;
		case ($urandom_range(0, 4))
			0: begin
				do h.protocol_number = 8'($urandom); while (h.protocol_number == PROTO_TCP);
			end
			1: h.buffer_length = 16'($urandom_range(0, need - 1));
			2: begin
				if (h.buffer_length == 16'hFFFF)
					h.buffer_length = 16'hFFFE;
				h.ip_total_length = 16'($urandom_range(int'(h.buffer_length) + 1, 65535));
			end
			3: begin
				if (fwd)
					h.dest_port ^= 16'($urandom_range(1, 65535));
				else
					h.source_port ^= 16'($urandom_range(1, 65535));
			end
			default: begin
				if (fwd)
					h.dest_ip ^= 32'($urandom_range(1, 32'h7FFFFFFF));
				else
					h.source_ip ^= 32'($urandom_range(1, 32'h7FFFFFFF));
			end
		endcase
		return h;
	endfunction

	// Directed headers on the reset register values.
	task automatic run_directed();
		in_item_t h;
		// Forward before the target has ever spoken: destination MAC is zero.
		send_header(client_header(16'd1234));
		// A non-TCP packet from the target teaches the target MAC and passes.
		h = target_reply(16'd1234);
		h.protocol_number = 8'd17;
		send_header(h);
		// Return to a client port that was never stored reads a zero entry.
		send_header(target_reply(16'd4321));
		send_header(client_header(16'd1234));
		send_header(target_reply(16'd1234));
		// Port and checksum extremes, all-ones and all-zero MACs.
		h = client_header(16'd0);
		h.ip_checksum = 16'h0000;
		h.tcp_checksum = 16'h0000;
		h.source_mac = '1;
		h.dest_mac = '1;
		send_header(h);
		h = client_header(16'hFFFF);
		h.ip_checksum = 16'hFFFF;
		h.tcp_checksum = 16'hFFFF;
		h.source_mac = '0;
		h.dest_mac = '0;
		send_header(h);
		send_header(target_reply(16'd0));
		send_header(target_reply(16'hFFFF));
		// Buffer one byte shorter than the headers.
		h = client_header(16'd77);
		h.buffer_length = 16'(int'(h.header_words) * 4 + TCP_HDR_BYTES - 1);
		h.ip_total_length = 16'd0;
		send_header(h);
		// Buffer shorter than the IP total length.
		h = client_header(16'd78);
		h.buffer_length = 16'd100;
		h.ip_total_length = 16'd101;
		send_header(h);
		// Header length field below five words is taken as is.
		h = client_header(16'd79);
		h.header_words = 4'd0;
		h.buffer_length = 16'd20;
		h.ip_total_length = 16'd20;
		send_header(h);
		// Longest IP header, exactly fitting, then one byte short.
		h = client_header(16'd80);
		h.header_words = 4'd15;
		h.buffer_length = 16'd80;
		h.ip_total_length = 16'd80;
		send_header(h);
		h.buffer_length = 16'd79;
		h.ip_total_length = 16'd79;
		send_header(h);
		// Protocol extremes on an otherwise matching client header.
		h = client_header(16'd81);
		h.protocol_number = 8'd0;
		send_header(h);
		h.protocol_number = 8'hFF;
		send_header(h);
		// Near misses of each rule.
		h = client_header(16'd82);
		h.dest_port = chk.cfg_local_port + 16'd1;
		send_header(h);
		h = target_reply(16'd1234);
		h.source_port = chk.cfg_target_port + 16'd1;
		send_header(h);
		h = target_reply(16'd1234);
		h.dest_ip = chk.cfg_local_ip + 32'd1;
		send_header(h);
		// A header that fits both rules must take the forward rule.
		h = client_header(chk.cfg_target_port);
		h.source_ip = chk.cfg_target_ip;
		send_header(h);
		send_header(in_item_t'('0));
		h = '1;
		h.tdata_pad = '0;
		send_header(h);
	endtask

	// Main sequence.
	initial begin : stimulus
		logic [15:0] ports[8];
		int          r;
		logic [15:0] port;

		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_directed();

		// Four register settings for the random part: random, all zero,
		// all one, random again. Each starts from an idle block.
		for (int ph = 0; ph < 4; ph++) begin
			drain_results();
			case (ph)
				1: program_ports('0, '0, '0, '0);
				2: program_ports('1, '1, '1, '1);
				default: program_ports($urandom, 16'($urandom), $urandom, 16'($urandom));
			endcase
			// A small set of client ports so that most replies find a stored entry.
			foreach (ports[j])
				ports[j] = 16'($urandom);
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				no_idle = (i >= 150 && i < 220);
				if (ph == 0 && i == 60)
					rx_hold_req = 1'b1;
				if (ph == 2 && i == 200)
					drain_results();
				port = $urandom_range(0, 99) < 75 ? ports[$urandom_range(0, 7)]
					: 16'($urandom);
				r = $urandom_range(0, 99);
				if (r < 40)
					send_header(client_header(port));
				else if (r < 70)
					send_header(target_reply(port));
				else if (r < 85)
					send_header(spoiled_header(port));
				else
					send_header(any_header());
			end
			no_idle = 1'b0;
		end

		drain_results();
		chk.check_leftovers();
		$display("Checked %0d forwarded, %0d returned and %0d passed headers",
			chk.n_forward, chk.n_return, chk.n_pass);
		$display("over the reset, zero, all-ones and two random port settings.");
		if (chk.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/pfnr_pkg.sv
design/pfnr_ram.sv
design/port_forward_nat_rewrite.sv
tb/tb_port_forward_nat_rewrite.sv
